[src/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic signed [31:0] NOT_FOUND_VALUE = -32'sd1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_item_t;

endpackage

[src/lkvc_store.sv]
// ----------------------------------------------------------------------------
// lkvc_store
// Entry storage, parallel key match, slot choice and recency rank update.
// ----------------------------------------------------------------------------
module lkvc_store #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lkvc_pkg::CAP_W-1:0]    capacity,
  input  logic                          req_valid,
  input  lkvc_pkg::req_item_t           req,
  output lkvc_pkg::rsp_item_t           rsp
);
  import lkvc_pkg::*;

  localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int UW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (UW > CAP_W) ? UW : CAP_W;

  logic [MAX_ENTRIES-1:0] valid;
  logic [RW-1:0]          rank [MAX_ENTRIES];
  logic [31:0]            entry_key [MAX_ENTRIES];
  logic [31:0]            entry_value [MAX_ENTRIES];
  logic [UW-1:0]          used;

  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] lru_vec;
  logic [MAX_ENTRIES-1:0] first_free;
  logic [MAX_ENTRIES-1:0] target;
  logic [MAX_ENTRIES-1:0] age;
  logic                   free_seen;
  logic                   have_hit;
  logic [31:0]            hit_value;
  logic [RW-1:0]          hit_rank;
  logic [31:0]            lru_key;
  logic [CW-1:0]          eff_cap;
  logic                   use_free;
  logic                   put_new;
  logic                   touch;
  logic [UW-1:0]          bound;

  always_comb begin
    hit_vec   = '0;
    lru_vec   = '0;
    first_free = '0;
    free_seen = 1'b0;
    hit_value = '0;
    hit_rank  = '0;
    lru_key   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = valid[i] && (entry_key[i] == req.key);
      lru_vec[i] = valid[i] && (rank[i] == RW'(used - 1'b1));
      first_free[i] = !valid[i] && !free_seen;
      free_seen = free_seen || !valid[i];
      hit_value = hit_value | (entry_value[i] & {32{hit_vec[i]}});
      hit_rank  = hit_rank | (rank[i] & {RW{hit_vec[i]}});
      lru_key   = lru_key | (entry_key[i] & {32{lru_vec[i]}});
    end
  end

  always_comb begin
    eff_cap = CW'(capacity);
    if (eff_cap == '0) begin
      eff_cap = CW'(1);
    end
    if (eff_cap > CW'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end
  end

  assign have_hit = |hit_vec;
  assign use_free = (CW'(used) < eff_cap) && free_seen;
  assign put_new  = (req.cmd == CMD_PUT) && !have_hit;
  assign touch    = req_valid && (have_hit || put_new);

  always_comb begin
    if (have_hit) begin
      bound  = UW'(hit_rank);
      target = hit_vec;
    end else if (use_free) begin
      bound  = used;
      target = first_free;
    end else begin
      bound  = used - 1'b1;
      target = lru_vec;
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      age[i] = valid[i] && !target[i] && (UW'(rank[i]) < bound);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      used  <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (touch) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (target[i]) begin
          valid[i] <= 1'b1;
          rank[i]  <= '0;
        end else if (age[i]) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
      if (put_new && use_free) begin
        used <= used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (touch && req.cmd == CMD_PUT) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (target[i]) begin
          entry_key[i]   <= req.key;
          entry_value[i] <= req.value;
        end
      end
    end
  end

  always_comb begin
    rsp.found       = have_hit;
    rsp.read_value  = (have_hit && req.cmd == CMD_GET) ? hit_value : NOT_FOUND_VALUE;
    rsp.evicted     = put_new && !use_free;
    rsp.evicted_key = (put_new && !use_free) ? lru_key : '0;
  end

endmodule

[src/lru_key_value_cache_core.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Path: a request is registered in the input stage and its result in the
//   result stage; rsp_valid rises when the result stage loads.
// Throughput: one item per cycle unless rsp_stall holds a valid result; key
//   match, slot choice and rank update are combinational between registers.
// Reset: valid marks, ranks, fill count and both stages clear at once;
//   capacity returns to 16.
module lru_key_value_cache_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  lkvc_pkg::req_item_t         req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output lkvc_pkg::rsp_item_t         rsp,
  input  logic                        cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data
);
  import lkvc_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic             stage_valid;
  req_item_t        stage_item;
  rsp_item_t        result;
  logic             advance;

  assign advance   = stage_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!req_stall) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      stage_item <= req;
    end
  end

  lkvc_store #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .req_valid(advance),
    .req      (stage_item),
    .rsp      (result)
  );

  // result stage; holds while the transfer is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

endmodule
